// ===== hw/rtl/vtbp_pkg.sv =====
// ---------------------------------------------------------------------------
// Vector terminal byte parser package
// Shared types, byte codes and result kinds for the parser core.
// ---------------------------------------------------------------------------
package vtbp_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Result kinds.
  localparam logic [3:0] KIND_LINE   = 4'd0;
  localparam logic [3:0] KIND_MOVE   = 4'd1;
  localparam logic [3:0] KIND_DOT    = 4'd2;
  localparam logic [3:0] KIND_CHAR   = 4'd3;
  localparam logic [3:0] KIND_HIDE   = 4'd4;
  localparam logic [3:0] KIND_TOGGLE = 4'd5;
  localparam logic [3:0] KIND_STYLE  = 4'd6;
  localparam logic [3:0] KIND_CLEAR  = 4'd7;
  localparam logic [3:0] KIND_HOST   = 4'd8;

  // Host byte codes.
  localparam logic [7:0] CC_ENQ    = 8'd5;
  localparam logic [7:0] CC_BEL    = 8'd7;
  localparam logic [7:0] CC_LF     = 8'd10;
  localparam logic [7:0] CC_FF     = 8'd12;
  localparam logic [7:0] CC_CR     = 8'd13;
  localparam logic [7:0] CC_ETB    = 8'd23;
  localparam logic [7:0] CC_SUB    = 8'd26;
  localparam logic [7:0] CC_ESC    = 8'd27;
  localparam logic [7:0] CC_FS     = 8'd28;
  localparam logic [7:0] CC_GS     = 8'd29;
  localparam logic [7:0] CC_RS     = 8'd30;
  localparam logic [7:0] CC_US     = 8'd31;
  localparam logic [7:0] CC_SPACE  = 8'd32;
  localparam logic [7:0] CC_HIGH   = 8'd128;
  localparam logic [7:0] ESC_SOLID = 8'd96;
  localparam logic [7:0] ESC_DOT   = 8'd97;
  localparam logic [7:0] ESC_DDASH = 8'd98;
  localparam logic [7:0] ESC_DASH  = 8'd99;
  localparam logic [7:0] REPLY_TAG = 8'hbb;

  // Crosshair row scaling: y = (768 - row) * 1.0156, rounding up from .5078.
  localparam logic [9:0]  ROW_MAX     = 10'd767;
  localparam logic [9:0]  ROW_SPAN    = 10'd768;
  localparam logic [13:0] SCALE_NUM   = 14'd10156;
  localparam logic [13:0] SCALE_DEN   = 14'd10000;
  localparam logic [12:0] ROUND_AT    = 13'd5078;
  localparam logic [12:0] RECIP       = 13'd6711;
  localparam int          RECIP_SHIFT = 26;

  // Result steps a command may ask for, in emission order.
  localparam int         NUM_STEPS     = 11;
  localparam logic [3:0] STEP_HIDE_PRE = 4'd0;
  localparam logic [3:0] STEP_MAIN     = 4'd1;
  localparam logic [3:0] STEP_HIDE_POST= 4'd2;
  localparam logic [3:0] STEP_TOGGLE   = 4'd3;
  localparam logic [3:0] STEP_LEAD     = 4'd4;
  localparam logic [3:0] STEP_TAG      = 4'd5;
  localparam logic [3:0] STEP_COL_HI   = 4'd6;
  localparam logic [3:0] STEP_COL_LO   = 4'd7;
  localparam logic [3:0] STEP_Y_HI     = 4'd8;
  localparam logic [3:0] STEP_Y_LO     = 4'd9;
  localparam logic [3:0] STEP_CR       = 4'd10;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [9:0] cross_col;
    logic [9:0] cross_row;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [11:0] from_x;
    logic [11:0] from_y;
    logic [11:0] to_x;
    logic [11:0] to_y;
    logic [7:0]  value;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [NUM_STEPS-1:0] steps;
    logic [3:0]           kind;
    logic [11:0]          from_x;
    logic [11:0]          from_y;
    logic [11:0]          to_x;
    logic [11:0]          to_y;
    logic [7:0]           value;
    logic [9:0]           col;
    logic [9:0]           row_dist;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== hw/rtl/vtbp_front.sv =====
// ---------------------------------------------------------------------------
// Vector terminal byte parser front end
// Tracks the parser modes and coordinate bytes and turns each host byte
// into at most one command for the back end.
// ---------------------------------------------------------------------------
module vtbp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  vtbp_pkg::in_item_t item,
  input  logic               report_mode,
  output logic               push,
  output vtbp_pkg::cmd_t     cmd
);

  logic        escape_pending, bypass, point_mode, graph_mode;
  logic        new_entity, crosshair_on, low_y_seen;
  logic [2:0]  byte_position;
  logic [4:0]  hi_x, hi_y, lo_y;
  logic [3:0]  extra_bits;
  logic [11:0] pen_x, pen_y;

  logic        escape_pending_next, bypass_next, point_mode_next, graph_mode_next;
  logic        new_entity_next, crosshair_on_next, low_y_seen_next;
  logic [2:0]  byte_position_next;
  logic [4:0]  hi_x_next, hi_y_next, lo_y_next;
  logic [3:0]  extra_bits_next;
  logic [11:0] pen_x_next, pen_y_next;

  logic [7:0]  c;
  logic [2:0]  bp_inc;
  logic [11:0] new_x, new_y;
  logic [9:0]  row_clamped;
  vtbp_pkg::cmd_t cmd_w;

  assign c           = item.rx_byte;
  assign bp_inc      = (byte_position == 3'd7) ? 3'd7 : byte_position + 3'd1;
  assign new_x       = {hi_x, c[4:0], extra_bits[1:0]};
  assign new_y       = {hi_y, lo_y, extra_bits[3:2]};
  assign row_clamped = (item.cross_row > vtbp_pkg::ROW_MAX) ? vtbp_pkg::ROW_MAX
                                                           : item.cross_row;

  always_comb begin
    escape_pending_next = escape_pending;
    bypass_next         = bypass;
    point_mode_next     = point_mode;
    graph_mode_next     = graph_mode;
    new_entity_next     = new_entity;
    crosshair_on_next   = crosshair_on;
    low_y_seen_next     = low_y_seen;
    byte_position_next  = byte_position;
    hi_x_next           = hi_x;
    hi_y_next           = hi_y;
    lo_y_next           = lo_y;
    extra_bits_next     = extra_bits;
    pen_x_next          = pen_x;
    pen_y_next          = pen_y;

    cmd_w          = '0;
    cmd_w.col      = item.cross_col;
    cmd_w.row_dist = vtbp_pkg::ROW_SPAN - row_clamped;

    if (escape_pending) begin
      escape_pending_next = 1'b0;
      case (c)
        vtbp_pkg::ESC_SOLID: begin
          cmd_w.steps[vtbp_pkg::STEP_MAIN] = 1'b1;
          cmd_w.kind  = vtbp_pkg::KIND_STYLE;
          cmd_w.value = 8'd0;
        end
        vtbp_pkg::ESC_DASH: begin
          cmd_w.steps[vtbp_pkg::STEP_MAIN] = 1'b1;
          cmd_w.kind  = vtbp_pkg::KIND_STYLE;
          cmd_w.value = 8'd1;
        end
        vtbp_pkg::ESC_DOT: begin
          cmd_w.steps[vtbp_pkg::STEP_MAIN] = 1'b1;
          cmd_w.kind  = vtbp_pkg::KIND_STYLE;
          cmd_w.value = 8'd4;
        end
        vtbp_pkg::ESC_DDASH: begin
          cmd_w.steps[vtbp_pkg::STEP_MAIN] = 1'b1;
          cmd_w.kind  = vtbp_pkg::KIND_STYLE;
          cmd_w.value = 8'd2;
        end
        vtbp_pkg::CC_FF: begin
          cmd_w.steps[vtbp_pkg::STEP_MAIN]      = 1'b1;
          cmd_w.steps[vtbp_pkg::STEP_HIDE_POST] = crosshair_on;
          cmd_w.kind      = vtbp_pkg::KIND_CLEAR;
          graph_mode_next = 1'b0;
          bypass_next     = 1'b0;
          point_mode_next = 1'b0;
          pen_x_next      = 12'd0;
          pen_y_next      = 12'd9;
        end
        vtbp_pkg::CC_SUB: begin
          cmd_w.steps[vtbp_pkg::STEP_MAIN] = 1'b1;
          cmd_w.kind        = vtbp_pkg::KIND_TOGGLE;
          bypass_next       = 1'b1;
          crosshair_on_next = 1'b1;
          point_mode_next   = 1'b0;
          graph_mode_next   = 1'b0;
          if (report_mode) begin
            // Show, hide again and report at once.
            cmd_w.steps[vtbp_pkg::STEP_HIDE_POST] = 1'b1;
            cmd_w.steps[vtbp_pkg::STEP_TOGGLE]    = 1'b1;
            cmd_w.steps[vtbp_pkg::STEP_CR:vtbp_pkg::STEP_TAG] = '1;
            bypass_next       = 1'b0;
            crosshair_on_next = 1'b0;
          end
        end
        vtbp_pkg::CC_ENQ: begin
          if (!crosshair_on) begin
            cmd_w.steps[vtbp_pkg::STEP_LEAD] = 1'b1;
            cmd_w.steps[vtbp_pkg::STEP_CR]   = 1'b1;
          end else begin
            cmd_w.steps[vtbp_pkg::STEP_LEAD] = !report_mode;
            cmd_w.steps[vtbp_pkg::STEP_CR:vtbp_pkg::STEP_TAG] = '1;
          end
        end
        vtbp_pkg::CC_ETB: begin
          bypass_next = 1'b0;
          cmd_w.steps[vtbp_pkg::STEP_HIDE_PRE] = crosshair_on;
        end
        default: begin
        end
      endcase
    end else if (c == vtbp_pkg::CC_ESC) begin
      escape_pending_next = 1'b1;
    end else if (c < vtbp_pkg::CC_SPACE) begin
      case (c)
        vtbp_pkg::CC_CR: begin
          bypass_next     = 1'b0;
          point_mode_next = 1'b0;
          graph_mode_next = 1'b0;
          cmd_w.steps[vtbp_pkg::STEP_HIDE_PRE] = crosshair_on;
          cmd_w.steps[vtbp_pkg::STEP_MAIN]     = 1'b1;
          cmd_w.kind  = vtbp_pkg::KIND_CHAR;
          cmd_w.value = c;
        end
        vtbp_pkg::CC_US: begin
          bypass_next     = 1'b0;
          point_mode_next = 1'b0;
          graph_mode_next = 1'b0;
          cmd_w.steps[vtbp_pkg::STEP_HIDE_PRE] = crosshair_on;
        end
        vtbp_pkg::CC_BEL: begin
          bypass_next = 1'b0;
          cmd_w.steps[vtbp_pkg::STEP_HIDE_PRE] = crosshair_on;
          cmd_w.steps[vtbp_pkg::STEP_MAIN]     = 1'b1;
          cmd_w.kind  = vtbp_pkg::KIND_CHAR;
          cmd_w.value = c;
        end
        default: begin
          if (!bypass) begin
            if (c == vtbp_pkg::CC_FS) begin
              graph_mode_next = 1'b1;
              point_mode_next = 1'b1;
            end else if (c == vtbp_pkg::CC_RS) begin
              graph_mode_next = 1'b0;
            end else if (c == vtbp_pkg::CC_GS) begin
              graph_mode_next = 1'b1;
              new_entity_next = 1'b1;
            end else if (c == vtbp_pkg::CC_LF) begin
              cmd_w.steps[vtbp_pkg::STEP_MAIN] = 1'b1;
              cmd_w.kind  = vtbp_pkg::KIND_CHAR;
              cmd_w.value = c;
            end
          end
        end
      endcase
    end else if (c < vtbp_pkg::CC_HIGH) begin
      if (!bypass) begin
        if (point_mode || graph_mode) begin
          byte_position_next = bp_inc;
          if (c[6]) begin
            if (!c[5]) begin
              // Low-x byte: the coordinate is complete.
              low_y_seen_next = 1'b0;
              cmd_w.steps[vtbp_pkg::STEP_MAIN] = 1'b1;
              cmd_w.to_x = new_x;
              cmd_w.to_y = new_y;
              if (point_mode) begin
                cmd_w.kind = vtbp_pkg::KIND_DOT;
              end else if (!new_entity) begin
                cmd_w.kind   = vtbp_pkg::KIND_LINE;
                cmd_w.from_x = pen_x;
                cmd_w.from_y = pen_y;
              end else begin
                cmd_w.kind      = vtbp_pkg::KIND_MOVE;
                new_entity_next = 1'b0;
              end
              pen_x_next         = new_x;
              pen_y_next         = new_y;
              byte_position_next = 3'd0;
            end else begin
              // A second low-y byte turns the earlier one into the extra byte.
              byte_position_next = 3'd2;
              if (low_y_seen) extra_bits_next = lo_y[3:0];
              lo_y_next       = c[4:0];
              low_y_seen_next = 1'b1;
            end
          end else if (bp_inc == 3'd1) begin
            hi_y_next = c[4:0];
          end else begin
            hi_x_next = c[4:0];
          end
        end else begin
          cmd_w.steps[vtbp_pkg::STEP_MAIN] = 1'b1;
          cmd_w.kind  = vtbp_pkg::KIND_CHAR;
          cmd_w.value = c;
        end
      end
    end
  end

  assign cmd  = cmd_w;
  assign push = accept && (|cmd_w.steps);

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      bypass         <= 1'b0;
      point_mode     <= 1'b0;
      graph_mode     <= 1'b0;
      new_entity     <= 1'b0;
      crosshair_on   <= 1'b0;
      low_y_seen     <= 1'b0;
      byte_position  <= 3'd0;
      hi_x           <= 5'd0;
      hi_y           <= 5'd0;
      lo_y           <= 5'd0;
      extra_bits     <= 4'd0;
      pen_x          <= 12'd0;
      pen_y          <= 12'd0;
    end else if (accept) begin
      escape_pending <= escape_pending_next;
      bypass         <= bypass_next;
      point_mode     <= point_mode_next;
      graph_mode     <= graph_mode_next;
      new_entity     <= new_entity_next;
      crosshair_on   <= crosshair_on_next;
      low_y_seen     <= low_y_seen_next;
      byte_position  <= byte_position_next;
      hi_x           <= hi_x_next;
      hi_y           <= hi_y_next;
      lo_y           <= lo_y_next;
      extra_bits     <= extra_bits_next;
      pen_x          <= pen_x_next;
      pen_y          <= pen_y_next;
    end
  end

endmodule

// ===== hw/rtl/vtbp_queue.sv =====
// ---------------------------------------------------------------------------
// Vector terminal byte parser command queue
// Small first-in first-out store between the front and back ends.
// ---------------------------------------------------------------------------
module vtbp_queue #(
  parameter int DEPTH = vtbp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  vtbp_pkg::cmd_t          push_cmd,
  input  logic                    pop,
  output vtbp_pkg::cmd_t          head,
  output vtbp_pkg::queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  vtbp_pkg::cmd_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign head         = entries[rd_ptr];
  assign status.full  = (count == FULL_CNT);
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== hw/rtl/vtbp_scale.sv =====
// ---------------------------------------------------------------------------
// Vector terminal byte parser row scaler
// Three-stage pipeline giving row_dist * 1.0156, rounded up from .5078, for crosshair reports.
// ---------------------------------------------------------------------------
module vtbp_scale (
  input  logic       clk,
  input  logic [9:0] row_dist,
  output logic [9:0] y
);

  logic [22:0] prod, prod_d;
  logic [9:0]  q_est;
  logic [35:0] recip_prod;
  logic [23:0] q_times_den;
  logic [23:0] rem;
  logic [23:0] rem_up;
  logic        neg;
  logic        round_up;

  assign recip_prod  = 36'(prod) * 36'(vtbp_pkg::RECIP);
  assign q_times_den = 24'(q_est) * 24'(vtbp_pkg::SCALE_DEN);
  assign rem         = {1'b0, prod_d} - q_times_den;
  assign rem_up      = rem + 24'(vtbp_pkg::SCALE_DEN);
  assign neg         = rem[23];

  // The reciprocal estimate is never low and at most one too high.
  always_comb begin
    if (neg) begin
      round_up = rem_up >= {11'd0, vtbp_pkg::ROUND_AT};
    end else begin
      round_up = rem >= {11'd0, vtbp_pkg::ROUND_AT};
    end
  end

  always_ff @(posedge clk) begin
    prod   <= 23'(24'(row_dist) * 24'(vtbp_pkg::SCALE_NUM));
    prod_d <= prod;
    q_est  <= recip_prod[vtbp_pkg::RECIP_SHIFT +: 10];
    y      <= q_est - 10'(neg) + 10'(round_up);
  end

endmodule

// ===== hw/rtl/vtbp_back.sv =====
// ---------------------------------------------------------------------------
// Vector terminal byte parser back end
// Takes commands from the queue and emits their result items one a cycle while out_stall is low.
// ---------------------------------------------------------------------------
module vtbp_back (
  input  logic                    clk,
  input  logic                    rst,
  input  vtbp_pkg::cmd_t          head,
  input  vtbp_pkg::queue_status_t q_status,
  output logic                    pop,
  output logic                    busy,
  output logic                    out_valid,
  input  logic                    out_stall,
  output vtbp_pkg::out_item_t     out_data
);

  vtbp_pkg::cmd_t                 cur;
  logic [vtbp_pkg::NUM_STEPS-1:0] pending;
  logic [vtbp_pkg::NUM_STEPS-1:0] lowest, rest;
  logic [3:0]                     step;
  logic [1:0]                     y_cnt;
  logic [9:0]                     y;
  logic                           y_ok, needs_y, fire, done;
  vtbp_pkg::out_item_t            item;

  vtbp_scale u_scale (
    .clk      (clk),
    .row_dist (cur.row_dist),
    .y        (y)
  );

  assign lowest = pending & (~pending + 1'b1);
  assign rest   = pending & ~lowest;
  assign busy   = |pending;

  always_comb begin
    step = vtbp_pkg::STEP_HIDE_PRE;
    for (int i = 0; i < vtbp_pkg::NUM_STEPS; i++) begin
      if (lowest[i]) step = 4'(i);
    end
  end

  assign y_ok      = (y_cnt == 2'd3);
  assign needs_y   = (step == vtbp_pkg::STEP_Y_HI) || (step == vtbp_pkg::STEP_Y_LO);
  assign out_valid = busy && (!needs_y || y_ok);
  assign fire      = out_valid && !out_stall;
  assign done      = !busy || (fire && (rest == '0));
  assign pop       = done && !q_status.empty;

  always_comb begin
    item      = '0;
    item.kind = vtbp_pkg::KIND_HOST;
    case (step)
      vtbp_pkg::STEP_HIDE_PRE,
      vtbp_pkg::STEP_HIDE_POST: item.kind = vtbp_pkg::KIND_HIDE;
      vtbp_pkg::STEP_MAIN: begin
        item.kind   = cur.kind;
        item.from_x = cur.from_x;
        item.from_y = cur.from_y;
        item.to_x   = cur.to_x;
        item.to_y   = cur.to_y;
        item.value  = cur.value;
      end
      vtbp_pkg::STEP_TOGGLE: item.kind  = vtbp_pkg::KIND_TOGGLE;
      vtbp_pkg::STEP_LEAD:   item.value = vtbp_pkg::CC_GS;
      vtbp_pkg::STEP_TAG:    item.value = vtbp_pkg::REPLY_TAG;
      vtbp_pkg::STEP_COL_HI: item.value = {3'b001, cur.col[9:5]};
      vtbp_pkg::STEP_COL_LO: item.value = {3'b001, cur.col[4:0]};
      vtbp_pkg::STEP_Y_HI:   item.value = {3'b001, y[9:5]};
      vtbp_pkg::STEP_Y_LO:   item.value = {3'b001, y[4:0]};
      vtbp_pkg::STEP_CR:     item.value = vtbp_pkg::CC_CR;
      default:               item.value = 8'd0;
    endcase
    item.last = (rest == '0);
  end

  assign out_data = item;

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      y_cnt   <= 2'd0;
    end else begin
      if (pop) begin
        pending <= head.steps;
      end else if (fire) begin
        pending <= rest;
      end
      // The counter holds back the row bytes until the scaler has the new command's row.
      if (pop) begin
        y_cnt <= 2'd0;
      end else if (!y_ok) begin
        y_cnt <= y_cnt + 2'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/vector_terminal_byte_parser_core.sv =====
// ---------------------------------------------------------------------------
// Vector terminal byte parser core
// Parses host bytes of a vector graphics terminal into drawing events and
// crosshair reply bytes.
// ---------------------------------------------------------------------------
// Throughput: one host byte a cycle while the command queue has room; results
// leave at one a cycle while out_stall is low.
// Path: a byte's command is registered in the queue and then in the back end's
// current-command register before its first result is valid; the row scaler's delay
// is hidden behind the reply bytes that precede the row.
// Reset: synchronous rst clears all parser modes, the pen, the queue and the
// report mode; the block accepts bytes in the first cycle after reset.
module vector_terminal_byte_parser_core #(
  parameter int QUEUE_DEPTH = vtbp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  vtbp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output vtbp_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  logic                    report_mode;
  logic                    accept, q_push, q_pop, back_busy;
  vtbp_pkg::cmd_t          push_cmd, head;
  vtbp_pkg::queue_status_t q_status;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_status.full;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      report_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      report_mode <= cfg_data;
    end
  end

  vtbp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (in_data),
    .report_mode (report_mode),
    .push        (q_push),
    .cmd         (push_cmd)
  );

  vtbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head),
    .status   (q_status)
  );

  vtbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (q_pop),
    .busy      (back_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A byte with results is waiting or being worked on in the next cycle.
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    q_push |=> (!q_status.empty || back_busy))
    else $error("pushed command lost between front and back end");

  // Output stops after the final result when nothing else is queued.
  a_last_stops: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_data.last && q_status.empty && !q_push)
      |=> !out_valid)
    else $error("result shown after the last one of the final command");

  // The back end never pops an empty queue.
  a_no_empty_pop: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("command popped from an empty queue");

endmodule

// ===== tb/tb_vector_terminal_byte_parser_core.sv =====
// ---------------------------------------------------------------------------
// Testbench for the vector terminal byte parser core
// Host bytes are queued by the stimulus process and sent by a clocked driver.
// Each transfer is run through a behavioural parser kept here, and its
// drawing events and reply bytes are queued as expected results. A clocked
// monitor compares each result transfer with the oldest expected event.
// The report mode is changed between phases while the core is idle.
// ---------------------------------------------------------------------------
module tb_vector_terminal_byte_parser_core;
  import vtbp_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int SETTLE_CYCLES    = 12;
  localparam int LONG_HOLD_AT     = 90;
  localparam int LONG_HOLD_CYCLES = 400;

  // Top bits of a coordinate byte: high x or y, low y, low x.
  localparam logic [2:0] TAG_HI   = 3'b001;
  localparam logic [2:0] TAG_LO_Y = 3'b011;
  localparam logic [2:0] TAG_LO_X = 3'b010;

  // Line styles as reported in the value field.
  localparam logic [2:0] LS_SOLID = 3'd0;
  localparam logic [2:0] LS_DASH  = 3'd1;
  localparam logic [2:0] LS_DDASH = 3'd2;
  localparam logic [2:0] LS_DOT   = 3'd4;

  localparam logic [11:0] HOME_Y = 12'd9;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  vector_terminal_byte_parser_core uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_item_t  host_bytes[$];
  out_item_t pending_events[$];
  out_item_t next_event;
  int        bytes_taken = 0;
  int        send_left = 0;
  int        recv_left = 0;
  int        mismatches = 0;
  int        cycle_count = 0;
  logic      long_hold_done = 1'b0;
  logic      calm = 1'b0;

  // Parser state as the host sees it.
  logic        esc_armed = 1'b0;
  logic        locked = 1'b0;
  logic        point_on = 1'b0;
  logic        graph_on = 1'b0;
  logic        fresh_vector = 1'b0;
  logic        cross_shown = 1'b0;
  logic        low_y_held = 1'b0;
  logic [2:0]  coord_pos = '0;
  logic [4:0]  high_x = '0;
  logic [4:0]  high_y = '0;
  logic [4:0]  low_y = '0;
  logic [3:0]  extra = '0;
  logic [11:0] pen_x = '0;
  logic [11:0] pen_y = '0;
  logic [2:0]  stroke_style = '0;
  logic        report_now = 1'b0;

  function automatic void add_event(logic [3:0] kind, logic [11:0] fx, logic [11:0] fy,
                                    logic [11:0] tx, logic [11:0] ty, logic [7:0] val);
    out_item_t ev;
    ev.kind = kind;
    ev.from_x = fx;
    ev.from_y = fy;
    ev.to_x = tx;
    ev.to_y = ty;
    ev.value = val;
    ev.last = 1'b0;
    pending_events.push_back(ev);
  endfunction

  function automatic void add_reply(logic [7:0] b);
    add_event(KIND_HOST, '0, '0, '0, '0, b);
  endfunction

  function automatic void add_hide_if_shown();
    if (cross_shown) add_event(KIND_HIDE, '0, '0, '0, '0, '0);
  endfunction

  function automatic void add_position_report(logic [9:0] col, logic [9:0] row, logic lead);
    logic [9:0]  row_c;
    logic [31:0] scaled;
    logic [31:0] ypos;
    row_c = (row > ROW_MAX) ? ROW_MAX : row;
    scaled = (32'(ROW_SPAN) - 32'(row_c)) * 32'(SCALE_NUM);
    ypos = scaled / 32'(SCALE_DEN);
    if (scaled % 32'(SCALE_DEN) >= 32'(ROUND_AT)) ypos = ypos + 1;
    if (lead) add_reply(CC_GS);
    add_reply(REPLY_TAG);
    add_reply({TAG_HI, col[9:5]});
    add_reply({TAG_HI, col[4:0]});
    add_reply({TAG_HI, ypos[9:5]});
    add_reply({TAG_HI, ypos[4:0]});
    add_reply(CC_CR);
  endfunction

  function automatic void take_escape(logic [7:0] c, logic [9:0] col, logic [9:0] row);
    esc_armed = 1'b0;
    case (c)
      ESC_SOLID: begin
        stroke_style = LS_SOLID;
        add_event(KIND_STYLE, '0, '0, '0, '0, 8'(LS_SOLID));
      end
      ESC_DASH: begin
        stroke_style = LS_DASH;
        add_event(KIND_STYLE, '0, '0, '0, '0, 8'(LS_DASH));
      end
      ESC_DOT: begin
        stroke_style = LS_DOT;
        add_event(KIND_STYLE, '0, '0, '0, '0, 8'(LS_DOT));
      end
      ESC_DDASH: begin
        stroke_style = LS_DDASH;
        add_event(KIND_STYLE, '0, '0, '0, '0, 8'(LS_DDASH));
      end
      CC_FF: begin
        add_event(KIND_CLEAR, '0, '0, '0, '0, '0);
        graph_on = 1'b0;
        locked = 1'b0;
        point_on = 1'b0;
        add_hide_if_shown();
        pen_x = '0;
        pen_y = HOME_Y;
      end
      CC_SUB: begin
        locked = 1'b1;
        cross_shown = 1'b1;
        add_event(KIND_TOGGLE, '0, '0, '0, '0, '0);
        point_on = 1'b0;
        graph_on = 1'b0;
        // In report mode the crosshair is shown, hidden and reported at once.
        if (report_now) begin
          add_event(KIND_HIDE, '0, '0, '0, '0, '0);
          locked = 1'b0;
          cross_shown = 1'b0;
          add_event(KIND_TOGGLE, '0, '0, '0, '0, '0);
          add_position_report(col, row, 1'b0);
        end
      end
      CC_ENQ: begin
        if (!cross_shown) begin
          add_reply(CC_GS);
          add_reply(CC_CR);
        end else begin
          add_position_report(col, row, !report_now);
        end
      end
      CC_ETB: begin
        locked = 1'b0;
        add_hide_if_shown();
      end
      default: ;
    endcase
  endfunction

  function automatic void take_coord(logic [7:0] c);
    logic [11:0] x;
    logic [11:0] y;
    if (coord_pos < 3'd7) coord_pos = coord_pos + 3'd1;
    if (c[6]) begin
      if (!c[5]) begin
        x = {high_x, c[4:0], extra[1:0]};
        y = {high_y, low_y, extra[3:2]};
        low_y_held = 1'b0;
        if (point_on) begin
          add_event(KIND_DOT, '0, '0, x, y, '0);
        end else if (!fresh_vector) begin
          add_event(KIND_LINE, pen_x, pen_y, x, y, '0);
        end else begin
          add_event(KIND_MOVE, '0, '0, x, y, '0);
          fresh_vector = 1'b0;
        end
        pen_x = x;
        pen_y = y;
        coord_pos = '0;
      end else begin
        // A repeated low-y byte turns the previous one into the extra byte.
        coord_pos = 3'd2;
        if (low_y_held) extra = low_y[3:0];
        low_y = c[4:0];
        low_y_held = 1'b1;
      end
    end else if (coord_pos == 3'd1) begin
      high_y = c[4:0];
    end else begin
      high_x = c[4:0];
    end
  endfunction

  function automatic void parse_host_byte(in_item_t it);
    int   first;
    logic [7:0] c;
    out_item_t tail;
    first = pending_events.size();
    c = it.rx_byte;
    if (esc_armed) begin
      take_escape(c, it.cross_col, it.cross_row);
    end else if (c == CC_ESC) begin
      esc_armed = 1'b1;
    end else if (c < CC_SPACE) begin
      case (c)
        CC_CR: begin
          locked = 1'b0;
          point_on = 1'b0;
          add_hide_if_shown();
          graph_on = 1'b0;
          add_event(KIND_CHAR, '0, '0, '0, '0, CC_CR);
        end
        CC_US: begin
          locked = 1'b0;
          point_on = 1'b0;
          add_hide_if_shown();
          graph_on = 1'b0;
        end
        CC_BEL: begin
          locked = 1'b0;
          add_hide_if_shown();
          add_event(KIND_CHAR, '0, '0, '0, '0, CC_BEL);
        end
        default: begin
          if (!locked) begin
            if (c == CC_FS) begin
              graph_on = 1'b1;
              point_on = 1'b1;
            end else if (c == CC_RS) begin
              graph_on = 1'b0;
            end else if (c == CC_GS) begin
              graph_on = 1'b1;
              fresh_vector = 1'b1;
            end else if (c == CC_LF) begin
              add_event(KIND_CHAR, '0, '0, '0, '0, CC_LF);
            end
          end
        end
      endcase
    end else if (c < CC_HIGH) begin
      if (!locked) begin
        if (point_on || graph_on) take_coord(c);
        else add_event(KIND_CHAR, '0, '0, '0, '0, c);
      end
    end
    if (pending_events.size() > first) begin
      tail = pending_events[pending_events.size() - 1];
      tail.last = 1'b1;
      pending_events[pending_events.size() - 1] = tail;
    end
  endfunction

  function automatic string show_result(out_item_t r);
    return $sformatf("kind %0d from (%0d,%0d) to (%0d,%0d) value %0d last %0b",
                     r.kind, r.from_x, r.from_y, r.to_x, r.to_y, r.value, r.last);
  endfunction

  function automatic void push_item(logic [7:0] c, logic [9:0] col, logic [9:0] row);
    in_item_t it;
    it.rx_byte = c;
    it.cross_col = col;
    it.cross_row = row;
    host_bytes.push_back(it);
  endfunction

  function automatic void push_byte(logic [7:0] c);
    push_item(c, 10'($urandom), 10'($urandom));
  endfunction

  function automatic int push_coord_group();
    int n;
    n = 1;
    if ($urandom_range(0, 2) != 0) begin
      push_byte({TAG_HI, 5'($urandom)});
      n++;
    end
    if ($urandom_range(0, 3) != 0) begin
      push_byte({TAG_LO_Y, 5'($urandom)});
      n++;
    end
    if ($urandom_range(0, 4) == 0) begin
      push_byte({TAG_LO_Y, 5'($urandom)});
      n++;
    end
    if ($urandom_range(0, 2) != 0) begin
      push_byte({TAG_HI, 5'($urandom)});
      n++;
    end
    push_byte({TAG_LO_X, 5'($urandom)});
    return n;
  endfunction

  // Queues one random fragment and returns how many bytes of it count.
  function automatic int push_random_fragment();
    int pick;
    int n;
    int groups;
    pick = $urandom_range(0, 19);
    n = 0;
    if (pick < 8) begin
      if ($urandom_range(0, 3) != 0) begin
        push_byte(($urandom_range(0, 2) == 0) ? CC_FS : CC_GS);
        n++;
      end
      groups = $urandom_range(1, 4);
      repeat (groups) n += push_coord_group();
    end else if (pick < 10) begin
      n = $urandom_range(1, 4);
      repeat (n) push_byte(8'($urandom_range(32, 127)));
    end else if (pick < 13) begin
      case ($urandom_range(0, 6))
        0: push_byte(CC_CR);
        1: push_byte(CC_US);
        2: push_byte(CC_BEL);
        3: push_byte(CC_LF);
        4: push_byte(CC_RS);
        default: push_byte(8'($urandom_range(0, 31)));
      endcase
      n = 1;
    end else if (pick < 17) begin
      push_byte(CC_ESC);
      case ($urandom_range(0, 10))
        0: push_byte(ESC_SOLID);
        1: push_byte(ESC_DASH);
        2: push_byte(ESC_DOT);
        3: push_byte(ESC_DDASH);
        4: push_byte(CC_FF);
        5, 6: push_byte(CC_SUB);
        7, 8: push_byte(CC_ENQ);
        9: push_byte(CC_ETB);
        default: push_byte(8'($urandom));
      endcase
      n = 2;
    end else if (pick < 18) begin
      push_byte(8'($urandom_range(128, 255)));
      n = 1;
    end else begin
      push_byte(8'($urandom));
      n = 1;
    end
    return n;
  endfunction

  task automatic queue_random_bytes(int count);
    int queued;
    queued = 0;
    @(negedge clk);
    while (queued < count) queued += push_random_fragment();
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (host_bytes.size() != 0 || in_valid || pending_events.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_report_mode(logic mode);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    report_now = mode;
  endtask

  // Sender: one byte offered at a time, held until the transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        parse_host_byte(in_data);
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (send_left > 0) begin
          in_valid <= 1'b0;
          send_left <= send_left - 1;
        end else if (host_bytes.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= host_bytes.pop_front();
          if (!calm && $urandom_range(0, 7) == 0) send_left <= $urandom_range(1, 13);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transfer and stalls in bursts.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          if (mismatches < 10) $display("unexpected result: %s", show_result(out_data));
          mismatches++;
        end else begin
          next_event = pending_events.pop_front();
          if (out_data !== next_event) begin
            if (mismatches < 10) begin
              $display("result mismatch: expected %s", show_result(next_event));
              $display("                 actual   %s", show_result(out_data));
            end
            mismatches++;
          end
        end
      end
      if (recv_left > 0) begin
        out_stall <= 1'b1;
        recv_left <= recv_left - 1;
      end else if (!long_hold_done && bytes_taken >= LONG_HOLD_AT) begin
        // Hold off long enough for the core to fill up and stall the sender.
        out_stall <= 1'b1;
        recv_left <= LONG_HOLD_CYCLES;
        long_hold_done <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        recv_left <= $urandom_range(0, 12);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_vector_terminal_byte_parser_core NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_report_mode(1'b0);

    @(negedge clk);
    push_item(CC_ESC, '0, '0);
    push_item(CC_ENQ, '0, '0);
    push_byte(CC_SPACE);
    push_byte(8'h7f);
    push_byte(8'hff);
    push_byte(CC_BEL);
    push_byte(CC_GS);
    push_byte({TAG_HI, 5'h1f});
    push_byte({TAG_LO_Y, 5'h00});
    push_byte({TAG_LO_Y, 5'h1f});
    push_byte({TAG_HI, 5'h00});
    push_byte({TAG_LO_X, 5'h1f});
    push_byte({TAG_LO_X, 5'h00});
    push_byte(CC_FS);
    push_byte({TAG_LO_X, 5'h15});
    push_byte(CC_ESC);
    push_byte(ESC_SOLID);
    push_byte(CC_ESC);
    push_byte(CC_SUB);
    push_byte(CC_ESC);
    push_item(CC_ENQ, 10'h3ff, 10'h3ff);
    push_byte(CC_ESC);
    push_byte(CC_FF);
    push_byte(CC_CR);
    wait_idle();

    // The crosshair is still shown here, so the first enquiry reports at once.
    write_report_mode(1'b1);
    @(negedge clk);
    push_byte(CC_ESC);
    push_item(CC_ENQ, '0, ROW_MAX);
    push_byte(CC_ESC);
    push_item(CC_SUB, 10'h3ff, '0);
    push_byte(CC_ESC);
    push_byte(CC_ENQ);
    push_byte(CC_ESC);
    push_byte(CC_ETB);
    push_byte(CC_ESC);
    push_byte(8'h41);
    push_byte(CC_RS);
    push_byte(CC_US);
    wait_idle();

    write_report_mode(1'b0);
    queue_random_bytes(140);
    wait_idle();

    write_report_mode(1'b1);
    queue_random_bytes(140);
    wait_idle();

    write_report_mode(1'b0);
    calm <= 1'b1;
    queue_random_bytes(100);
    wait_idle();

    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("tb_vector_terminal_byte_parser_core OK");
    end else begin
      $display("tb_vector_terminal_byte_parser_core NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/vtbp_pkg.sv
hw/rtl/vtbp_front.sv
hw/rtl/vtbp_queue.sv
hw/rtl/vtbp_scale.sv
hw/rtl/vtbp_back.sv
hw/rtl/vector_terminal_byte_parser_core.sv
tb/tb_vector_terminal_byte_parser_core.sv
